### rtl/lvrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear volume read splitter package
// Geometry constants, request and result types, and the control and status
// bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package lvrs_pkg;

    // Volume geometry. Every figure is a power of two, so addresses split
    // into disk, block and offset by plain bit fields.
    localparam int DISK_COUNT      = 16;
    localparam int BLOCKS_PER_DISK = 256;
    localparam int BLOCK_BYTES     = 256;
    localparam int MAX_READ_BYTES  = 1024;

    localparam int OFF_W = $clog2(BLOCK_BYTES);
    localparam int BLK_W = $clog2(BLOCKS_PER_DISK);
    localparam int DSK_W = $clog2(DISK_COUNT);
    localparam int VOL_W = OFF_W + BLK_W + DSK_W;

    // Field widths of the transactions.
    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 32;
    localparam int DISK_W  = 4;
    localparam int BLOCK_W = 8;
    localparam int OFFS_W  = 8;
    localparam int CHUNK_W = 9;
    localparam int TOTAL_W = 11;

    localparam logic [ADDR_W:0]    VOLUME_BYTES = (ADDR_W + 1)'(1) << VOL_W;
    localparam logic [COUNT_W-1:0] MAX_READ     = COUNT_W'(MAX_READ_BYTES);
    localparam logic [CHUNK_W-1:0] BLOCK_SIZE   = CHUNK_W'(BLOCK_BYTES);

    typedef enum logic [1:0] {
        MODE_MOUNT   = 2'd0,
        MODE_UNMOUNT = 2'd1,
        MODE_READ    = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [ADDR_W-1:0]  start_address;
        logic [COUNT_W-1:0] byte_count;
        logic               buffer_present;
        logic               device_ok;
    } t_in_item;

    typedef struct packed {
        logic               status;
        logic [DISK_W-1:0]  disk_index;
        logic [BLOCK_W-1:0] block_index;
        logic [OFFS_W-1:0]  byte_offset;
        logic [CHUNK_W-1:0] chunk_bytes;
        logic [TOTAL_W-1:0] bytes_so_far;
        logic               is_last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic emit_single;
        logic emit_chunk;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
        logic single;
        logic chunk_last;
    } t_dp_stat;

endpackage
`default_nettype wire

### rtl/lvrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear volume read splitter controller
// Sequences one request: capture, then one result or a run of descriptors.
// ----------------------------------------------------------------------------
module lvrs_ctrl
    import lvrs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_dp_stat i_stat,
    output t_ctl_cmd      o_cmd,
    output logic          o_in_stall
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SPLIT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (i_stat.out_free) begin
                        if (i_stat.single || i_stat.chunk_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_SPLIT;
                        end
                    end
                end
                ST_SPLIT: begin
                    if (i_stat.out_free && i_stat.chunk_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            ST_EVAL: begin
                o_cmd.emit_single = i_stat.out_free && i_stat.single;
                o_cmd.emit_chunk  = i_stat.out_free && !i_stat.single;
            end
            ST_SPLIT: begin
                o_cmd.emit_chunk = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule
`default_nettype wire

### rtl/lvrs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear volume read splitter datapath
// Holds the mounted flag, the captured request, the chunk walker and the
// output register.
// ----------------------------------------------------------------------------
module lvrs_dp
    import lvrs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_in_data,
    input  wire t_ctl_cmd i_cmd,
    input  wire logic     i_out_stall,
    output t_dp_stat      o_stat,
    output logic          o_out_valid,
    output t_out_item     o_out_data
);

    logic               r_mounted;
    t_in_item           r_req;
    logic [ADDR_W-1:0]  r_addr;
    logic [TOTAL_W-1:0] r_done;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [ADDR_W:0]    end_addr;
    logic               read_ok;
    logic               single;
    logic               single_status;
    logic               mount_change;
    logic [OFFS_W-1:0]  offset;
    logic [CHUNK_W-1:0] room;
    logic [TOTAL_W-1:0] len;
    logic [TOTAL_W-1:0] left;
    logic [CHUNK_W-1:0] chunk;
    logic [TOTAL_W-1:0] n_done;
    logic               chunk_last;

    assign end_addr = {1'b0, r_req.start_address} + {1'b0, r_req.byte_count};

    assign read_ok = r_mounted
                  && ({1'b0, r_req.start_address} < VOLUME_BYTES)
                  && (r_req.byte_count <= MAX_READ)
                  && (end_addr <= VOLUME_BYTES)
                  && (r_req.buffer_present || (r_req.byte_count == '0));

    always_comb begin
        single        = 1'b1;
        single_status = 1'b1;
        mount_change  = 1'b0;
        unique case (r_req.mode)
            MODE_MOUNT: begin
                mount_change  = !r_mounted && r_req.device_ok;
                single_status = !mount_change;
            end
            MODE_UNMOUNT: begin
                mount_change  = r_mounted && r_req.device_ok;
                single_status = !mount_change;
            end
            MODE_READ: begin
                single        = !read_ok || (r_req.byte_count == '0);
                single_status = !read_ok;
            end
            default: begin
                single        = 1'b1;
                single_status = 1'b1;
            end
        endcase
    end

    // The chunk never exceeds the room left in the current block.
    assign offset     = r_addr[OFF_W-1:0];
    assign room       = BLOCK_SIZE - {1'b0, offset};
    assign len        = r_req.byte_count[TOTAL_W-1:0];
    assign left       = len - r_done;
    assign chunk      = (left >= {2'b00, room}) ? room : left[CHUNK_W-1:0];
    assign n_done     = r_done + {2'b00, chunk};
    assign chunk_last = (n_done >= len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mounted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit_single || i_cmd.emit_chunk) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit_single && mount_change) begin
                r_mounted <= (r_req.mode == MODE_MOUNT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_in_data;
            r_addr <= i_in_data.start_address;
            r_done <= '0;
        end else if (i_cmd.emit_chunk) begin
            r_addr <= r_addr + ADDR_W'(chunk);
            r_done <= n_done;
        end
        if (i_cmd.emit_single) begin
            r_out <= '{status:       single_status,
                       disk_index:   '0,
                       block_index:  '0,
                       byte_offset:  '0,
                       chunk_bytes:  '0,
                       bytes_so_far: '0,
                       is_last:      1'b1};
        end else if (i_cmd.emit_chunk) begin
            r_out.status       <= 1'b0;
            r_out.disk_index   <= r_addr[VOL_W-1 -: DSK_W];
            r_out.block_index  <= r_addr[OFF_W +: BLK_W];
            r_out.byte_offset  <= offset;
            r_out.chunk_bytes  <= chunk;
            r_out.bytes_so_far <= n_done;
            r_out.is_last      <= chunk_last;
        end
    end

    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_stat.single     = single;
    assign o_stat.chunk_last = chunk_last;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule
`default_nettype wire

### rtl/linear_volume_read_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear volume read splitter
// Mount, unmount and read requests against a linear volume of 16 disks of
// 256 blocks of 256 bytes; valid reads are split into per-block descriptors.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the input channel (i_in_valid, o_in_stall, i_in_data).
// A transaction is accepted on a rising edge with valid high and stall low.
// Results leave on the output channel (o_out_valid, i_out_stall, o_out_data),
// one transaction per result, the final one of each request with is_last set.
// Mount, unmount, a rejected read and an empty read give one result; a valid
// read gives one descriptor for each block it touches, at most five.
// Timing: the request is captured in ST_IDLE and checked in ST_EVAL, which
// also delivers the first result into the output register once it is free.
// Each further descriptor follows in ST_SPLIT while the output register can
// take it. The controller works on one request at a time and holds
// o_in_stall high until the last result of the current one is registered.
// When the receiver stalls, the output register keeps its transaction and
// the controller waits; nothing is dropped or repeated.
// Reset (synchronous, active low) leaves the volume unmounted, the output
// channel empty and the controller ready for a new request.
// ----------------------------------------------------------------------------
module linear_volume_read_splitter
    import lvrs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_data
);

    // Command and status bundles between the sequencer and the datapath.
    t_ctl_cmd cmd;
    t_dp_stat stat;

    // The controller decides when to capture a request and when to emit a
    // single result or the next descriptor.
    lvrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath keeps the mounted flag, validates the request, walks the
    // address block by block and holds the result register.
    lvrs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear volume read splitter testbench
// Drives mount, unmount and read requests with random gaps, predicts every
// status and block descriptor from a behavioral split of the volume address
// space, and checks each output transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import lvrs_pkg::*;

    // Volume geometry in byte units, held at 64 bits so that address plus
    // length never wraps while a read is being validated.
    localparam logic [63:0] DISK_SPAN  = 64'(BLOCKS_PER_DISK) * 64'(BLOCK_BYTES);
    localparam logic [63:0] VOLUME_END = DISK_SPAN * 64'(DISK_COUNT);
    localparam int          STALL_LIMIT = 1000;
    localparam int          RANDOM_REQUESTS = 155;

    // One pending request for the driver. A request marked drain_first is
    // held back until every result predicted so far has been received.
    typedef struct {
        t_in_item item;
        bit       drain_first;
    } t_pending_req;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    t_pending_req req_queue[$];
    t_out_item    expected_results[$];

    // Behavioral copy of the volume state.
    bit vol_mounted;

    int errors;
    int stim_total;
    int sent_count;
    int results_owed;
    int results_done;
    int send_gap;
    int stall_left;
    int stuck_cycles;
    bit long_hold_done;
    int split_reads;
    int descriptors;
    int rejections;

    logic sender_idles;
    logic receiver_idles;

    linear_volume_read_splitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Idling comes and goes in stretches and stops entirely for the last
    // thirty requests, so the tail of the run streams at full rate.
    assign sender_idles   = (sent_count + 30 < stim_total) && ((sent_count / 25) % 4 != 3);
    assign receiver_idles = (sent_count + 30 < stim_total) && ((results_done / 30) % 4 != 1);

    // Applies one request to the volume model, appends the results it causes
    // to the expected queue and returns how many there are.
    function automatic int predict_request(input t_in_item req);
        logic [63:0] addr;
        logic [63:0] len;
        logic [63:0] done;
        logic [63:0] room;
        logic [63:0] chunk;
        t_out_item   res;
        bit          want;
        bit          read_ok;
        int          count;

        res         = '0;
        res.is_last = 1'b1;
        count       = 1;
        case (req.mode)
            MODE_MOUNT, MODE_UNMOUNT: begin
                want = (req.mode == MODE_MOUNT);
                if (vol_mounted == want || !req.device_ok) begin
                    res.status = 1'b1;
                end else begin
                    vol_mounted = want;
                end
                expected_results.push_back(res);
            end
            MODE_READ: begin
                addr    = 64'(req.start_address);
                len     = 64'(req.byte_count);
                read_ok = vol_mounted && addr < VOLUME_END && len <= 64'(MAX_READ_BYTES)
                          && addr + len <= VOLUME_END && (req.buffer_present || len == 0);
                if (!read_ok || len == 0) begin
                    res.status = !read_ok;
                    expected_results.push_back(res);
                end else begin
                    // One descriptor per touched block; each takes whatever is
                    // left of the block or of the request, whichever is less.
                    count = 0;
                    done  = 0;
                    split_reads++;
                    while (done < len) begin
                        res.status      = 1'b0;
                        res.disk_index  = DISK_W'(addr / DISK_SPAN);
                        res.block_index = BLOCK_W'((addr % DISK_SPAN) / 64'(BLOCK_BYTES));
                        res.byte_offset = OFFS_W'(addr % 64'(BLOCK_BYTES));
                        room            = 64'(BLOCK_BYTES) - (addr % 64'(BLOCK_BYTES));
                        chunk           = (len - done >= room) ? room : len - done;
                        done            = done + chunk;
                        addr            = addr + chunk;
                        res.chunk_bytes  = CHUNK_W'(chunk);
                        res.bytes_so_far = TOTAL_W'(done);
                        res.is_last      = (done >= len);
                        expected_results.push_back(res);
                        count++;
                    end
                    descriptors += count;
                end
            end
            default: begin
                res.status = 1'b1;
                expected_results.push_back(res);
            end
        endcase
        if (count == 1 && expected_results[$].status) begin
            rejections++;
        end
        return count;
    endfunction

    function automatic int field_diff(input string name, input int unsigned want,
                                      input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic queue_request(input t_mode mode, input logic [31:0] addr,
                                 input logic [31:0] len, input logic buf_ok,
                                 input logic dev_ok, input bit drain);
        t_pending_req p;

        p.item.mode           = mode;
        p.item.start_address  = addr;
        p.item.byte_count     = len;
        p.item.buffer_present = buf_ok;
        p.item.device_ok      = dev_ok;
        p.drain_first         = drain;
        req_queue.push_back(p);
    endtask

    // Driver: offers the head of the request queue. The payload only moves on
    // once the current transaction has been taken, and every accepted request
    // goes through the predictor at the edge where it was accepted.
    always @(posedge i_clk) begin
        int owed_now;

        owed_now = results_owed;
        if (!i_rst_n) begin
            in_valid     <= 1'b0;
            send_gap     <= 0;
            sent_count   <= 0;
            results_owed <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                owed_now = owed_now + predict_request(in_data);
                void'(req_queue.pop_front());
                sent_count <= sent_count + 1;
            end
            results_owed <= owed_now;
            if (!in_valid || !in_stall) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (req_queue.size() == 0 ||
                             (req_queue[0].drain_first && owed_now != results_done)) begin
                    in_valid <= 1'b0;
                end else if (sender_idles && $urandom_range(0, 5) == 0) begin
                    // An idle burst of random length, this one included.
                    send_gap <= $urandom_range(0, 10);
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_data  <= req_queue[0].item;
                end
            end
        end
    end

    // Monitor: checks every accepted result and drives the output stall.
    // Once, after forty results, the receiver holds off long enough that the
    // output register fills and the block pushes back on its input.
    always @(posedge i_clk) begin
        t_out_item want;

        if (!i_rst_n) begin
            out_stall      <= 1'b0;
            stall_left     <= 0;
            results_done   <= 0;
            long_hold_done <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, out_data);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    errors += field_diff("status", want.status, out_data.status)
                            + field_diff("disk_index", want.disk_index, out_data.disk_index)
                            + field_diff("block_index", want.block_index, out_data.block_index)
                            + field_diff("byte_offset", want.byte_offset, out_data.byte_offset)
                            + field_diff("chunk_bytes", want.chunk_bytes, out_data.chunk_bytes)
                            + field_diff("bytes_so_far", want.bytes_so_far,
                                         out_data.bytes_so_far)
                            + field_diff("is_last", want.is_last, out_data.is_last);
                end
                results_done <= results_done + 1;
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end else if (!long_hold_done && results_done >= 40) begin
                long_hold_done <= 1'b1;
                stall_left     <= 79;
                out_stall      <= 1'b1;
            end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 10);
                out_stall  <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if no transaction moves on either channel for
    // far longer than the longest deliberate hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, stuck_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        t_in_item    r;
        int          kind;
        logic [31:0] len;

        // Directed part: state errors, the unused mode, the empty read, the
        // largest reads, and every validation rule at its boundary.
        queue_request(MODE_READ, 32'd0, 32'd16, 1'b1, 1'b1, 1'b0);    // read unmounted
        queue_request(MODE_UNMOUNT, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0);  // already unmounted
        queue_request(MODE_MOUNT, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);    // device refuses
        queue_request(MODE_MOUNT, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0);
        queue_request(MODE_MOUNT, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0);    // already mounted
        queue_request(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        queue_request(MODE_READ, 32'd77, 32'd0, 1'b0, 1'b0, 1'b0);    // empty read
        queue_request(MODE_READ, 32'd0, 32'd1, 1'b1, 1'b0, 1'b0);
        queue_request(MODE_READ, 32'd0, 32'd1024, 1'b1, 1'b1, 1'b0);
        queue_request(MODE_READ, 32'd128, 32'd1024, 1'b1, 1'b1, 1'b0); // five blocks
        queue_request(MODE_READ, 32'd0, 32'd1025, 1'b1, 1'b1, 1'b0);   // too long
        queue_request(MODE_READ, 32'(VOLUME_END - 1), 32'd1, 1'b1, 1'b1, 1'b0);
        queue_request(MODE_READ, 32'(VOLUME_END - 10), 32'd11, 1'b1, 1'b1, 1'b0);
        queue_request(MODE_READ, 32'(VOLUME_END - 10), 32'd10, 1'b1, 1'b1, 1'b0);
        queue_request(MODE_READ, 32'(VOLUME_END), 32'd0, 1'b1, 1'b1, 1'b0);
        queue_request(MODE_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        queue_request(MODE_READ, 32'hFFFF_FF00, 32'h0000_0200, 1'b1, 1'b1, 1'b0);
        queue_request(MODE_READ, 32'd500, 32'd5, 1'b0, 1'b1, 1'b0);    // no buffer
        queue_request(MODE_READ, 32'(DISK_SPAN - 100), 32'd300, 1'b1, 1'b1, 1'b0);
        queue_request(MODE_UNMOUNT, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);  // device refuses
        queue_request(MODE_UNMOUNT, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0);
        queue_request(MODE_UNMOUNT, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0);  // already unmounted
        queue_request(MODE_READ, 32'd256, 32'd256, 1'b1, 1'b1, 1'b0);
        queue_request(MODE_MOUNT, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0);

        // Random part: mostly well-formed reads on a mounted volume, with
        // boundary cases, state changes and some pure noise mixed in.
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            r                = '0;
            r.device_ok      = ($urandom_range(0, 4) != 0);
            r.buffer_present = 1'b1;
            kind             = $urandom_range(0, 99);
            if (kind < 7) begin
                r.mode = MODE_MOUNT;
            end else if (kind < 12) begin
                r.mode = MODE_UNMOUNT;
            end else if (kind < 15) begin
                r.mode           = MODE_UNUSED;
                r.start_address  = $urandom;
                r.byte_count     = $urandom;
                r.buffer_present = $urandom_range(0, 1);
            end else begin
                r.mode = MODE_READ;
                case ($urandom_range(0, 9))
                    0: begin
                        r.start_address  = $urandom;
                        r.byte_count     = $urandom;
                        r.buffer_present = $urandom_range(0, 1);
                    end
                    1: begin
                        r.start_address = 32'(VOLUME_END) - $urandom_range(1, 1100);
                        r.byte_count    = $urandom_range(0, 1100);
                    end
                    2: begin
                        r.start_address = $urandom_range(0, 32'(VOLUME_END - 1));
                        r.byte_count    = $urandom_range(1020, 1030);
                    end
                    3: begin
                        r.start_address  = $urandom_range(0, 32'(VOLUME_END - 1));
                        r.byte_count     = $urandom_range(0, 8);
                        r.buffer_present = 1'b0;
                    end
                    default: begin
                        // Starts on or just short of a block boundary half of
                        // the time, to exercise full and one-byte chunks.
                        if ($urandom_range(0, 1) == 0) begin
                            r.start_address = $urandom_range(0, 32'(VOLUME_END - 1));
                        end else begin
                            r.start_address = ($urandom_range(0, 4095) << 8)
                                            + ($urandom_range(0, 1) ? 0 : $urandom_range(250, 255));
                        end
                        case ($urandom_range(0, 3))
                            0:       len = $urandom_range(1, 8);
                            1:       len = 1024 - $urandom_range(0, 3);
                            2:       len = $urandom_range(1, 1024);
                            default: len = $urandom_range(1, 4) * 256;
                        endcase
                        r.byte_count = len;
                    end
                endcase
            end
            queue_request(r.mode, r.start_address, r.byte_count, r.buffer_present,
                          r.device_ok, (i == 0 || i == 70));
            // An unmount is usually followed by a mount so that reads keep
            // getting past validation.
            if (r.mode == MODE_UNMOUNT && $urandom_range(0, 3) != 0) begin
                queue_request(MODE_MOUNT, $urandom, $urandom, 1'b1, 1'b1, 1'b0);
            end
        end
        stim_total = req_queue.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last request to be taken and its results to arrive,
        // then leave time for any stray transaction to show up.
        @(negedge i_clk);
        while (req_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
        end

        $display("Sent %0d requests; %0d reads were split into %0d block descriptors.",
                 stim_total, split_reads, descriptors);
        $display("%0d requests were rejected by state or validation checks.", rejections);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
